[sv/tlphd_pkg.sv]
package tlphd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // word position codes
  localparam logic [2:0] POS_W0   = 3'd0;
  localparam logic [2:0] POS_W1   = 3'd1;
  localparam logic [2:0] POS_W2   = 3'd2;
  localparam logic [2:0] POS_W3   = 3'd3;
  localparam logic [2:0] POS_BODY = 3'd4;
  localparam logic [2:0] POS_DROP = 3'd5;
  localparam logic [2:0] POS_BAD  = 3'd6;

  localparam logic [1:0] KIND_HDR     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DIGEST  = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  localparam logic [2:0] CLS_MEM  = 3'd0;
  localparam logic [2:0] CLS_IO   = 3'd1;
  localparam logic [2:0] CLS_CFG  = 3'd2;
  localparam logic [2:0] CLS_MSG  = 3'd3;
  localparam logic [2:0] CLS_CPL  = 3'd4;
  localparam logic [2:0] CLS_NONE = 3'd7;

  localparam logic [4:0] TYPE_MRD0  = 5'd0;
  localparam logic [4:0] TYPE_MRD1  = 5'd1;
  localparam logic [4:0] TYPE_IO    = 5'd2;
  localparam logic [4:0] TYPE_CFG0  = 5'd4;
  localparam logic [4:0] TYPE_CFG1  = 5'd5;
  localparam logic [4:0] TYPE_CPL0  = 5'd10;
  localparam logic [4:0] TYPE_CPL1  = 5'd11;
  localparam logic [4:0] TYPE_MSG_RC   = 5'd16;
  localparam logic [4:0] TYPE_MSG_ADDR = 5'd17;
  localparam logic [4:0] TYPE_MSG_ID   = 5'd18;
  localparam logic [4:0] TYPE_MSG_BC   = 5'd19;
  localparam logic [4:0] TYPE_MSG_LOC  = 5'd20;
  localparam logic [4:0] TYPE_MSG_GAT  = 5'd21;

  localparam logic [10:0] LEN_MAX = 11'd1024;
  localparam logic [12:0] BC_MAX  = 13'd4096;

  typedef struct packed {
    logic [31:0] dword;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  tlp_class;
    logic [4:0]  type_code;
    logic [10:0] header_attrs;
    logic [10:0] length_dw;
    logic [15:0] requester_id;
    logic [7:0]  request_tag;
    logic [7:0]  enables_or_code;
    logic [2:0]  completion_status;
    logic [12:0] byte_count;
    logic [63:0] value;
    logic        end_of_packet;
  } out_t;

  typedef struct packed {
    logic [2:0]  pos;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic        held_valid;
    logic [31:0] held_dword;
  } state_t;

  function automatic logic [2:0] class_of(logic [4:0] t);
    logic [2:0] c;
    case (t)
      TYPE_MRD0, TYPE_MRD1: c = CLS_MEM;
      TYPE_IO:              c = CLS_IO;
      TYPE_CFG0, TYPE_CFG1: c = CLS_CFG;
      TYPE_MSG_RC, TYPE_MSG_ADDR, TYPE_MSG_ID,
      TYPE_MSG_BC, TYPE_MSG_LOC, TYPE_MSG_GAT: c = CLS_MSG;
      TYPE_CPL0, TYPE_CPL1: c = CLS_CPL;
      default:              c = CLS_NONE;
    endcase
    return c;
  endfunction

endpackage

[sv/tlphd_decode.sv]
module tlphd_decode import tlphd_pkg::*; (
  input  state_t     st_i,
  input  in_t        in_i,
  output state_t     st_o,
  output out_t       rec0_o,
  output out_t       rec1_o,
  output logic [1:0] n_o
);

  function automatic out_t make_plain(logic [1:0] kind, logic [31:0] val, logic eop);
    out_t r;
    r = '0;
    r.record_kind   = kind;
    r.value         = {32'd0, val};
    r.end_of_packet = eop;
    return r;
  endfunction

  function automatic out_t make_header(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                       logic [31:0] cur, logic [2:0] cls, logic eop);
    out_t       r;
    logic [4:0] t;
    logic       data;
    logic       four;
    logic       np;
    r    = '0;
    t    = w0[28:24];
    data = w0[30];
    four = w0[29];
    case (cls)
      CLS_MEM:         np = ~data;
      CLS_IO, CLS_CFG: np = 1'b1;
      default:         np = 1'b0;
    endcase
    r.record_kind  = KIND_HDR;
    r.tlp_class    = cls;
    r.type_code    = t;
    r.header_attrs = {w0[22:20], 1'b0, w0[12], w0[13], w0[14], w0[15], np, four, data};
    r.length_dw    = (w0[9:0] == 10'd0) ? LEN_MAX : {1'b0, w0[9:0]};
    r.requester_id = w1[31:16];
    if (cls == CLS_CPL) begin
      r.header_attrs[7]   = w1[12];
      r.completion_status = w1[15:13];
      r.byte_count        = (w1[11:0] == 12'd0) ? BC_MAX : {1'b0, w1[11:0]};
    end else begin
      r.request_tag     = w1[15:8];
      r.enables_or_code = w1[7:0];
    end
    if (cls == CLS_MEM || cls == CLS_IO || t == TYPE_MSG_ADDR) begin
      if (four) r.value = {w2, cur[31:2], 2'b00};
      else      r.value = {32'd0, w2[31:2], 2'b00};
    end else if (cls == CLS_CFG) begin
      r.value = {32'd0, w2 & 32'hFFFF_0FFC};
    end else if (cls == CLS_CPL) begin
      r.value = {32'd0, w2 & 32'hFFFF_FF7F};
    end else if (t == TYPE_MSG_ID) begin
      r.value = {32'd0, w2[31:16], 16'd0};
    end
    r.end_of_packet = eop;
    return r;
  endfunction

  logic [31:0] dw;
  logic        last;
  logic [31:0] w2_eff;
  logic [2:0]  cls;
  logic        td;
  logic        finish;

  assign dw     = in_i.dword;
  assign last   = in_i.last;
  assign w2_eff = (st_i.pos == POS_W2) ? dw : st_i.w2;
  assign cls    = class_of(st_i.w0[28:24]);
  assign td     = st_i.w0[15];

  always_comb begin
    st_o   = st_i;
    rec0_o = '0;
    rec1_o = '0;
    n_o    = 2'd0;
    finish = 1'b0;
    case (st_i.pos)
      POS_W0, POS_W1: begin
        if (st_i.pos == POS_W0) st_o.w0 = dw;
        else                    st_o.w1 = dw;
        if (last) begin
          st_o.pos        = POS_W0;
          st_o.held_valid = 1'b0;
          rec0_o          = make_plain(KIND_BAD, 32'd0, 1'b1);
          n_o             = 2'd1;
        end else begin
          st_o.pos = st_i.pos + 3'd1;
        end
      end
      POS_W2: begin
        st_o.w2 = dw;
        if (!st_i.w0[29]) begin
          finish = 1'b1;
        end else if (last) begin
          st_o.pos        = POS_W0;
          st_o.held_valid = 1'b0;
          rec0_o          = make_plain(KIND_BAD, 32'd0, 1'b1);
          n_o             = 2'd1;
        end else begin
          st_o.pos = POS_W3;
        end
      end
      POS_W3: finish = 1'b1;
      POS_BODY: begin
        if (!td) begin
          rec0_o = make_plain(KIND_PAYLOAD, dw, last);
          n_o    = 2'd1;
          if (last) begin
            st_o.pos        = POS_W0;
            st_o.held_valid = 1'b0;
          end
        end else if (last) begin
          // if a dword is held it goes out as payload; the final one is the digest
          st_o.pos        = POS_W0;
          st_o.held_valid = 1'b0;
          if (st_i.held_valid) begin
            rec0_o = make_plain(KIND_PAYLOAD, st_i.held_dword, 1'b0);
            rec1_o = make_plain(KIND_DIGEST, dw, 1'b1);
            n_o    = 2'd2;
          end else begin
            rec0_o = make_plain(KIND_DIGEST, dw, 1'b1);
            n_o    = 2'd1;
          end
        end else begin
          if (st_i.held_valid) begin
            rec0_o = make_plain(KIND_PAYLOAD, st_i.held_dword, 1'b0);
            n_o    = 2'd1;
          end
          st_o.held_dword = dw;
          st_o.held_valid = 1'b1;
        end
      end
      POS_DROP: begin
        if (last) begin
          st_o.pos        = POS_W0;
          st_o.held_valid = 1'b0;
        end
      end
      default: begin
        if (last) begin
          st_o.pos        = POS_W0;
          st_o.held_valid = 1'b0;
          rec0_o          = make_plain(KIND_BAD, 32'd0, 1'b1);
          n_o             = 2'd1;
        end
      end
    endcase

    if (finish) begin
      if (cls == CLS_NONE) begin
        if (last) begin
          st_o.pos        = POS_W0;
          st_o.held_valid = 1'b0;
          rec0_o          = make_plain(KIND_BAD, 32'd0, 1'b1);
          n_o             = 2'd1;
        end else begin
          st_o.pos = POS_BAD;
        end
      end else if (last) begin
        st_o.pos        = POS_W0;
        st_o.held_valid = 1'b0;
        n_o             = 2'd1;
        // digest announced but nothing follows the header
        if (td) rec0_o = make_plain(KIND_BAD, 32'd0, 1'b1);
        else    rec0_o = make_header(st_i.w0, st_i.w1, w2_eff, dw, cls, 1'b1);
      end else begin
        rec0_o          = make_header(st_i.w0, st_i.w1, w2_eff, dw, cls, 1'b0);
        n_o             = 2'd1;
        st_o.pos        = (st_i.w0[30] || td) ? POS_BODY : POS_DROP;
        st_o.held_valid = 1'b0;
      end
    end
  end

endmodule

[sv/tlp_header_deframer.sv]
// A record is offered once its dword has passed the input register and been decoded into
// the output queue. Throughput: one dword per cycle while the queue has room; the final
// dword of a digest packet can make two records, which drain from the 4-entry output
// queue one per cycle while out_ready_i is high.
// Reset: asynchronous, active low; clears packet position, hold flag and queue.
module tlp_header_deframer import tlphd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic             s1_valid_q;
  in_t              s1_q;
  state_t           st_q, st_d;
  out_t             rec0, rec1;
  logic [1:0]       dec_n;
  out_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             room;
  logic             s1_fire;
  logic             pop;
  logic [1:0]       push_n;

  tlphd_decode u_decode (
    .st_i   (st_q),
    .in_i   (s1_q),
    .st_o   (st_d),
    .rec0_o (rec0),
    .rec1_o (rec1),
    .n_o    (dec_n)
  );

  assign room       = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign s1_fire    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || room;
  assign push_n     = s1_fire ? dec_n : 2'd0;

  assign out_valid_o = count_q != '0;
  assign out_data_o  = fifo_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign count_d     = count_q + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      st_q.pos        <= POS_W0;
      st_q.w0         <= '0;
      st_q.w1         <= '0;
      st_q.w2         <= '0;
      st_q.held_valid <= 1'b0;
      st_q.held_dword <= '0;
      wr_q          <= '0;
      rd_q          <= '0;
      count_q       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        st_q <= st_d;
      end
      wr_q    <= wr_q + PTR_W'(push_n);
      if (pop) rd_q <= rd_q + PTR_W'(1);
      count_q <= count_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_q <= in_data_i;
    if (push_n != 2'd0) fifo_q[wr_q] <= rec0;
    if (push_n == 2'd2) fifo_q[wr_q + PTR_W'(1)] <= rec1;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_pair_is_payload_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && dec_n == 2'd2) |->
      (rec0.record_kind == KIND_PAYLOAD && rec1.record_kind == KIND_DIGEST
       && rec1.end_of_packet))
    else $error("two records from one dword must be payload then digest");

  a_last_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.last) |=> (st_q.pos == POS_W0 && !st_q.held_valid))
    else $error("packet state not cleared after last dword");

endmodule
